// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mcaq_pkg.sv -----
// ---------------------------------------------------------------------------
// Motion command admission queue package
// Sizes, codes, word layouts and shared helpers of the admission queue.
// ---------------------------------------------------------------------------
package mcaq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int AXES        = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int POS_W     = 32;
  localparam int LIMIT_W   = 31;
  localparam int FEED_W    = 16;
  localparam int ID_W      = 16;
  localparam int ARG_W     = 16;
  localparam int KIND_W    = 3;
  localparam int CODE_W    = 3;
  localparam int REQ_W     = 2;
  localparam int MASK_W    = 5;
  localparam int REG_IDX_W = 3;

  localparam int AX_X = 0;
  localparam int AX_Y = 1;
  localparam int AX_Z = 2;
  localparam int AX_A = 3;

  localparam logic [REQ_W-1:0] REQ_SUBMIT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PULL   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RETIRE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_WAIT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SPINDLE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DRILL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_GOTO    = 3'd3;

  localparam logic [CODE_W-1:0] RESP_OK        = 3'd0;
  localparam logic [CODE_W-1:0] RESP_INVALID   = 3'd1;
  localparam logic [CODE_W-1:0] RESP_FULL      = 3'd2;
  localparam logic [CODE_W-1:0] RESP_NO_PULL   = 3'd3;
  localparam logic [CODE_W-1:0] RESP_NO_RETIRE = 3'd4;

  localparam logic [REG_IDX_W-1:0] REG_LIMIT_X    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_Y    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_Z    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_A    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FEED_LIMIT = 3'd4;

  localparam logic [ARG_W-1:0]   SPINDLE_MAX      = 16'd60000;
  localparam logic [MASK_W-1:0]  FEED_GIVEN       = 5'h10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 31'h7FFF_FFFF;
  localparam logic [FEED_W-1:0]  FEED_LIMIT_RESET = 16'd1500;
  localparam logic [FEED_W-1:0]  PREV_FEED_RESET  = 16'd150;
  localparam logic [POS_W-1:0]   LAST_POS_RESET   = 32'h7FFF_FFFF;

  typedef logic [AXES-1:0][POS_W-1:0]   pos_vec_t;
  typedef logic [AXES-1:0][LIMIT_W-1:0] limit_vec_t;

  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic [KIND_W-1:0]       cmd_kind;
    logic [ID_W-1:0]         cmd_id;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [POS_W-1:0] pos_a;
    logic [FEED_W-1:0]       feed_rate;
    logic [MASK_W-1:0]       present_mask;
    logic [ARG_W-1:0]        clearance;
    logic [ARG_W-1:0]        count_arg;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0]       resp_code;
    logic [KIND_W-1:0]       out_kind;
    logic [ID_W-1:0]         out_id;
    logic signed [POS_W-1:0] out_x;
    logic signed [POS_W-1:0] out_y;
    logic signed [POS_W-1:0] out_z;
    logic signed [POS_W-1:0] out_a;
    logic [FEED_W-1:0]       out_feed;
    logic [ARG_W-1:0]        out_clearance;
    logic [ARG_W-1:0]        out_count;
    logic [CNT_W-1:0]        free_slots;
  } out_word_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic [FEED_W-1:0] feed;
    pos_vec_t          pos;
    logic [ARG_W-1:0]  clearance;
    logic [ARG_W-1:0]  count;
  } slot_t;

  typedef struct packed {
    logic            ok;
    slot_t           slot;
    logic [AXES-1:0] pos_upd;
    pos_vec_t        new_pos;
    logic            feed_upd;
  } chk_t;

  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ----- design/mcaq_slot_ram.sv -----
// ---------------------------------------------------------------------------
// Slot store
// Queue slot memory with one write port and registered pull and retire reads.
// ---------------------------------------------------------------------------
module mcaq_slot_ram (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [mcaq_pkg::PTR_W-1:0]  wr_addr,
  input  mcaq_pkg::slot_t             wr_data,
  input  logic                        rd_en,
  input  logic [mcaq_pkg::PTR_W-1:0]  pull_addr,
  input  logic [mcaq_pkg::PTR_W-1:0]  retire_addr,
  output mcaq_pkg::slot_t             pull_data,
  output mcaq_pkg::slot_t             retire_data
);

  mcaq_pkg::slot_t mem [mcaq_pkg::QUEUE_DEPTH];
  mcaq_pkg::slot_t pull_data_r;
  mcaq_pkg::slot_t retire_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read of the slot being written returns the new contents.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      pull_data_r   <= (wr_en && wr_addr == pull_addr) ? wr_data : mem[pull_addr];
      retire_data_r <= (wr_en && wr_addr == retire_addr) ? wr_data : mem[retire_addr];
    end
  end

  assign pull_data   = pull_data_r;
  assign retire_data = retire_data_r;

endmodule

// ----- design/mcaq_check.sv -----
// ---------------------------------------------------------------------------
// Command check
// Fills in missing goto axes and feed and checks a command against limits.
// ---------------------------------------------------------------------------
module mcaq_check (
  input  mcaq_pkg::in_word_t                 item,
  input  mcaq_pkg::limit_vec_t               limit,
  input  logic [mcaq_pkg::FEED_W-1:0]        feed_limit,
  input  mcaq_pkg::pos_vec_t                 last_pos,
  input  logic [mcaq_pkg::FEED_W-1:0]        prev_feed,
  output mcaq_pkg::chk_t                     chk
);

  mcaq_pkg::pos_vec_t                p;
  mcaq_pkg::pos_vec_t                goto_pos;
  logic [mcaq_pkg::AXES-1:0]         drill_in;
  logic [mcaq_pkg::AXES-1:0]         goto_in;
  logic [mcaq_pkg::FEED_W-1:0]       goto_feed;
  logic signed [mcaq_pkg::POS_W:0]   ztop;
  logic signed [mcaq_pkg::POS_W:0]   depth;
  logic                              ztop_ok;
  logic                              depth_ok;

  assign p[mcaq_pkg::AX_X] = item.pos_x;
  assign p[mcaq_pkg::AX_Y] = item.pos_y;
  assign p[mcaq_pkg::AX_Z] = item.pos_z;
  assign p[mcaq_pkg::AX_A] = item.pos_a;

  always_comb begin
    for (int i = 0; i < mcaq_pkg::AXES; i++) begin
      goto_pos[i] = item.present_mask[i] ? p[i] : last_pos[i];
      drill_in[i] = $signed(p[i]) <= $signed({1'b0, limit[i]});
      goto_in[i]  = $signed(goto_pos[i]) <= $signed({1'b0, limit[i]});
    end
  end

  assign goto_feed = ((item.present_mask & mcaq_pkg::FEED_GIVEN) != '0) ?
                     item.feed_rate : prev_feed;

  assign ztop = $signed({p[mcaq_pkg::AX_Z][mcaq_pkg::POS_W-1], p[mcaq_pkg::AX_Z]}) +
                $signed({{(mcaq_pkg::POS_W + 1 - mcaq_pkg::ARG_W){1'b0}}, item.clearance});
  assign ztop_ok = ztop <= $signed({2'b00, limit[mcaq_pkg::AX_Z]});

  assign depth = $signed({p[mcaq_pkg::AX_Z][mcaq_pkg::POS_W-1], p[mcaq_pkg::AX_Z]}) -
                 $signed({p[mcaq_pkg::AX_A][mcaq_pkg::POS_W-1], p[mcaq_pkg::AX_A]});
  assign depth_ok = !depth[mcaq_pkg::POS_W];

  always_comb begin
    chk           = '0;
    chk.slot.kind = item.cmd_kind;
    chk.slot.id   = item.cmd_id;
    case (item.cmd_kind)
      mcaq_pkg::KIND_WAIT: begin
        chk.ok         = item.count_arg != '0;
        chk.slot.count = item.count_arg;
      end
      mcaq_pkg::KIND_SPINDLE: begin
        chk.ok         = item.count_arg <= mcaq_pkg::SPINDLE_MAX;
        chk.slot.count = item.count_arg;
      end
      mcaq_pkg::KIND_DRILL: begin
        chk.ok = drill_in[mcaq_pkg::AX_X] && drill_in[mcaq_pkg::AX_Y] && ztop_ok &&
                 depth_ok && (item.feed_rate <= feed_limit) && (item.count_arg != '0);
        chk.slot.pos       = p;
        chk.slot.feed      = item.feed_rate;
        chk.slot.clearance = item.clearance;
        chk.slot.count     = item.count_arg;
        chk.new_pos        = p;
        chk.new_pos[mcaq_pkg::AX_Z]   = ztop[mcaq_pkg::POS_W-1:0];
        chk.pos_upd[mcaq_pkg::AX_X]   = 1'b1;
        chk.pos_upd[mcaq_pkg::AX_Y]   = 1'b1;
        chk.pos_upd[mcaq_pkg::AX_Z]   = 1'b1;
      end
      mcaq_pkg::KIND_GOTO: begin
        chk.ok        = (goto_feed <= feed_limit) && (&goto_in);
        chk.slot.pos  = goto_pos;
        chk.slot.feed = goto_feed;
        chk.new_pos   = goto_pos;
        chk.pos_upd   = '1;
        chk.feed_upd  = 1'b1;
      end
      default: begin
        chk.ok = 1'b0;
      end
    endcase
  end

endmodule

// ----- design/motion_command_admission_queue.sv -----
// ---------------------------------------------------------------------------
// Motion command admission queue
// Checks wait, spindle, drill and goto commands and keeps accepted ones in a
// ring queue with separate pull and retire pointers.
// ---------------------------------------------------------------------------
// Every request word returns exactly one response word. A word is taken into
// an input register together with the registered read of the slot store, and
// its response is formed into the output register when that one is empty or
// its word is taken, so one word can be accepted in every cycle while the
// response side takes words; the registered read port of the slot store sets
// this two-stage depth. The slot store has no clearing pass after reset.
`include "assert_macros.svh"

module motion_command_admission_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [mcaq_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [mcaq_pkg::LIMIT_W-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  mcaq_pkg::in_word_t               in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output mcaq_pkg::out_word_t              out_word
);

  logic                             a_valid_r;
  mcaq_pkg::in_word_t               a_item_r;
  logic                             out_valid_r;
  mcaq_pkg::out_word_t              out_word_r;
  mcaq_pkg::out_word_t              res;

  logic [mcaq_pkg::PTR_W-1:0]       write_ptr_r, write_ptr_nxt;
  logic [mcaq_pkg::PTR_W-1:0]       read_ptr_r, read_ptr_nxt;
  logic [mcaq_pkg::PTR_W-1:0]       retire_ptr_r, retire_ptr_nxt;
  logic [mcaq_pkg::CNT_W-1:0]       free_r, free_nxt;
  logic [mcaq_pkg::CNT_W-1:0]       ready_r, ready_nxt;
  mcaq_pkg::pos_vec_t               last_pos_r, last_pos_nxt;
  logic [mcaq_pkg::FEED_W-1:0]      prev_feed_r, prev_feed_nxt;
  logic [mcaq_pkg::ID_W-1:0]        last_id_r, last_id_nxt;
  mcaq_pkg::limit_vec_t             limit_r;
  logic [mcaq_pkg::FEED_W-1:0]      feed_limit_r;

  logic                             commit;
  logic                             in_acc;
  logic                             wr_en;
  logic                             sub_ack;
  logic [mcaq_pkg::CNT_W:0]         occupied;
  mcaq_pkg::slot_t                  pull_slot;
  mcaq_pkg::slot_t                  retire_slot;
  mcaq_pkg::chk_t                   chk;

  assign commit    = a_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = a_valid_r && !commit;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign occupied  = {1'b0, free_r} + {1'b0, ready_r};

  mcaq_check u_check (
    .item       (a_item_r),
    .limit      (limit_r),
    .feed_limit (feed_limit_r),
    .last_pos   (last_pos_r),
    .prev_feed  (prev_feed_r),
    .chk        (chk)
  );

  mcaq_slot_ram u_slot_ram (
    .clk         (clk),
    .wr_en       (wr_en),
    .wr_addr     (write_ptr_r),
    .wr_data     (chk.slot),
    .rd_en       (in_acc),
    .pull_addr   (read_ptr_nxt),
    .retire_addr (retire_ptr_nxt),
    .pull_data   (pull_slot),
    .retire_data (retire_slot)
  );

  always_comb begin
    res            = '0;
    write_ptr_nxt  = write_ptr_r;
    read_ptr_nxt   = read_ptr_r;
    retire_ptr_nxt = retire_ptr_r;
    free_nxt       = free_r;
    ready_nxt      = ready_r;
    last_pos_nxt   = last_pos_r;
    prev_feed_nxt  = prev_feed_r;
    last_id_nxt    = last_id_r;
    wr_en          = 1'b0;
    sub_ack        = 1'b0;
    res.out_id     = last_id_r;
    if (commit) begin
      case (a_item_r.req_type)
        mcaq_pkg::REQ_SUBMIT: begin
          res.out_kind = a_item_r.cmd_kind;
          if (free_r == '0) begin
            res.resp_code = mcaq_pkg::RESP_FULL;
          end else if (!chk.ok) begin
            res.resp_code = mcaq_pkg::RESP_INVALID;
          end else begin
            res.resp_code = mcaq_pkg::RESP_OK;
            res.out_id    = a_item_r.cmd_id;
            wr_en         = 1'b1;
            sub_ack       = 1'b1;
            write_ptr_nxt = mcaq_pkg::ptr_adv(write_ptr_r);
            free_nxt      = free_r - 1'b1;
            ready_nxt     = ready_r + 1'b1;
            last_id_nxt   = a_item_r.cmd_id;
            for (int i = 0; i < mcaq_pkg::AXES; i++) begin
              if (chk.pos_upd[i]) begin
                last_pos_nxt[i] = chk.new_pos[i];
              end
            end
            if (chk.feed_upd) begin
              prev_feed_nxt = chk.slot.feed;
            end
          end
        end
        mcaq_pkg::REQ_PULL: begin
          if (ready_r == '0) begin
            res.resp_code = mcaq_pkg::RESP_NO_PULL;
          end else begin
            res.resp_code     = mcaq_pkg::RESP_OK;
            res.out_kind      = pull_slot.kind;
            res.out_id        = pull_slot.id;
            res.out_x         = pull_slot.pos[mcaq_pkg::AX_X];
            res.out_y         = pull_slot.pos[mcaq_pkg::AX_Y];
            res.out_z         = pull_slot.pos[mcaq_pkg::AX_Z];
            res.out_a         = pull_slot.pos[mcaq_pkg::AX_A];
            res.out_feed      = pull_slot.feed;
            res.out_clearance = pull_slot.clearance;
            res.out_count     = pull_slot.count;
            read_ptr_nxt      = mcaq_pkg::ptr_adv(read_ptr_r);
            ready_nxt         = ready_r - 1'b1;
          end
        end
        mcaq_pkg::REQ_RETIRE: begin
          if (occupied == (mcaq_pkg::CNT_W + 1)'(mcaq_pkg::QUEUE_DEPTH)) begin
            res.resp_code = mcaq_pkg::RESP_NO_RETIRE;
          end else begin
            res.resp_code  = mcaq_pkg::RESP_OK;
            res.out_kind   = retire_slot.kind;
            res.out_id     = retire_slot.id;
            retire_ptr_nxt = mcaq_pkg::ptr_adv(retire_ptr_r);
            free_nxt       = free_r + 1'b1;
          end
        end
        default: begin
          res.resp_code = mcaq_pkg::RESP_INVALID;
        end
      endcase
    end
    res.free_slots = free_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      write_ptr_r  <= '0;
      read_ptr_r   <= '0;
      retire_ptr_r <= '0;
      free_r       <= mcaq_pkg::CNT_W'(mcaq_pkg::QUEUE_DEPTH);
      ready_r      <= '0;
      last_pos_r   <= {mcaq_pkg::AXES{mcaq_pkg::LAST_POS_RESET}};
      prev_feed_r  <= mcaq_pkg::PREV_FEED_RESET;
      last_id_r    <= '0;
      limit_r      <= {mcaq_pkg::AXES{mcaq_pkg::LIMIT_RESET}};
      feed_limit_r <= mcaq_pkg::FEED_LIMIT_RESET;
    end else begin
      if (in_acc) begin
        a_valid_r <= 1'b1;
      end else if (commit) begin
        a_valid_r <= 1'b0;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      write_ptr_r  <= write_ptr_nxt;
      read_ptr_r   <= read_ptr_nxt;
      retire_ptr_r <= retire_ptr_nxt;
      free_r       <= free_nxt;
      ready_r      <= ready_nxt;
      last_pos_r   <= last_pos_nxt;
      prev_feed_r  <= prev_feed_nxt;
      last_id_r    <= last_id_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          mcaq_pkg::REG_LIMIT_X:    limit_r[mcaq_pkg::AX_X] <= cfg_data;
          mcaq_pkg::REG_LIMIT_Y:    limit_r[mcaq_pkg::AX_Y] <= cfg_data;
          mcaq_pkg::REG_LIMIT_Z:    limit_r[mcaq_pkg::AX_Z] <= cfg_data;
          mcaq_pkg::REG_LIMIT_A:    limit_r[mcaq_pkg::AX_A] <= cfg_data;
          mcaq_pkg::REG_FEED_LIMIT: feed_limit_r <= cfg_data[mcaq_pkg::FEED_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_item_r <= in_word;
    end
    if (commit) begin
      out_word_r <= res;
    end
  end

  `ASSERT_ALWAYS(a_occupancy_bound, occupied <= (mcaq_pkg::CNT_W + 1)'(mcaq_pkg::QUEUE_DEPTH), "free and ready slots exceed the queue depth")
  `ASSERT_NEXT(a_submit_takes_slot, sub_ack, free_r == $past(free_r) - 1'b1, "accepted submit did not take a free slot")
  `ASSERT_IMPLY(a_stall_needs_word, in_stall, a_valid_r && out_valid_r, "input stalled without a held word")

endmodule

// ----- test/mcaq_reply_checker.sv -----
// ---------------------------------------------------------------------------
// Admission queue reply checker
// Watches the request, reply and register ports of the admission queue,
// predicts the reply word for every accepted request word and compares the
// replies in order, field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcaq_reply_checker
  import mcaq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_word_t             in_word,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_word_t            out_word,
  output int                   reply_faults,
  output int                   replies_owed
);

  slot_t             cmd_store [QUEUE_DEPTH];
  int                push_at;
  int                pull_at;
  int                retire_at;
  int                free_cnt;
  int                ready_cnt;
  longint            last_pos [AXES];
  logic [FEED_W-1:0] prev_feed;
  logic [ID_W-1:0]   last_id;
  longint            travel_cap [AXES];
  logic [FEED_W-1:0] feed_cap;
  out_word_t         awaited_replies [$];
  int                faults = 0;
  int                reply_no = 0;

  function automatic int next_slot(int p);
    return (p + 1 == QUEUE_DEPTH) ? 0 : p + 1;
  endfunction

  task automatic clear_queue_state();
    push_at   = 0;
    pull_at   = 0;
    retire_at = 0;
    free_cnt  = QUEUE_DEPTH;
    ready_cnt = 0;
    for (int i = 0; i < AXES; i++) begin
      last_pos[i]   = longint'($signed(LAST_POS_RESET));
      travel_cap[i] = longint'(LIMIT_RESET);
    end
    prev_feed = PREV_FEED_RESET;
    last_id   = '0;
    feed_cap  = FEED_LIMIT_RESET;
  endtask

  // The free slot count is always reported after the request took effect.
  function automatic out_word_t make_reply(logic [CODE_W-1:0] code,
                                           logic [KIND_W-1:0] kind,
                                           logic [ID_W-1:0]   id);
    out_word_t r;
    r            = '0;
    r.resp_code  = code;
    r.out_kind   = kind;
    r.out_id     = id;
    r.free_slots = CNT_W'(free_cnt);
    return r;
  endfunction

  function automatic out_word_t submit_command(in_word_t w);
    slot_t             s;
    longint            p [AXES];
    longint            filled [AXES];
    logic [FEED_W-1:0] feed;
    logic              ok;
    if (free_cnt == 0) begin
      return make_reply(RESP_FULL, w.cmd_kind, last_id);
    end
    p[AX_X] = longint'($signed(w.pos_x));
    p[AX_Y] = longint'($signed(w.pos_y));
    p[AX_Z] = longint'($signed(w.pos_z));
    p[AX_A] = longint'($signed(w.pos_a));
    s       = '0;
    s.kind  = w.cmd_kind;
    s.id    = w.cmd_id;
    ok      = 1'b0;
    case (w.cmd_kind)
      KIND_WAIT: begin
        ok      = w.count_arg != '0;
        s.count = w.count_arg;
      end
      KIND_SPINDLE: begin
        ok      = w.count_arg <= SPINDLE_MAX;
        s.count = w.count_arg;
      end
      KIND_DRILL: begin
        ok = p[AX_X] <= travel_cap[AX_X] && p[AX_Y] <= travel_cap[AX_Y] &&
             p[AX_Z] + longint'(w.clearance) <= travel_cap[AX_Z] &&
             p[AX_Z] - p[AX_A] >= 0 && w.feed_rate <= feed_cap && w.count_arg != '0;
        if (ok) begin
          for (int i = 0; i < AXES; i++) begin
            s.pos[i] = POS_W'(p[i]);
          end
          s.feed       = w.feed_rate;
          s.clearance  = w.clearance;
          s.count      = w.count_arg;
          last_pos[AX_X] = p[AX_X];
          last_pos[AX_Y] = p[AX_Y];
          last_pos[AX_Z] = p[AX_Z] + longint'(w.clearance);
        end
      end
      KIND_GOTO: begin
        for (int i = 0; i < AXES; i++) begin
          filled[i] = w.present_mask[i] ? p[i] : last_pos[i];
          s.pos[i]  = POS_W'(filled[i]);
        end
        feed   = ((w.present_mask & FEED_GIVEN) != '0) ? w.feed_rate : prev_feed;
        s.feed = feed;
        ok     = feed <= feed_cap;
        for (int i = 0; i < AXES; i++) begin
          if (filled[i] > travel_cap[i]) begin
            ok = 1'b0;
          end
        end
        if (ok) begin
          prev_feed = feed;
          for (int i = 0; i < AXES; i++) begin
            last_pos[i] = filled[i];
          end
        end
      end
      default: ok = 1'b0;
    endcase
    if (!ok) begin
      return make_reply(RESP_INVALID, w.cmd_kind, last_id);
    end
    cmd_store[push_at] = s;
    push_at            = next_slot(push_at);
    free_cnt--;
    ready_cnt++;
    last_id = s.id;
    return make_reply(RESP_OK, s.kind, s.id);
  endfunction

  function automatic out_word_t admit_request(in_word_t w);
    out_word_t r;
    slot_t     s;
    case (w.req_type)
      REQ_SUBMIT: r = submit_command(w);
      REQ_PULL: begin
        if (ready_cnt == 0) begin
          r = make_reply(RESP_NO_PULL, '0, last_id);
        end else begin
          s       = cmd_store[pull_at];
          pull_at = next_slot(pull_at);
          ready_cnt--;
          r               = make_reply(RESP_OK, s.kind, s.id);
          r.out_x         = s.pos[AX_X];
          r.out_y         = s.pos[AX_Y];
          r.out_z         = s.pos[AX_Z];
          r.out_a         = s.pos[AX_A];
          r.out_feed      = s.feed;
          r.out_clearance = s.clearance;
          r.out_count     = s.count;
        end
      end
      REQ_RETIRE: begin
        // Only commands already pulled for execution may be retired.
        if (QUEUE_DEPTH - free_cnt - ready_cnt == 0) begin
          r = make_reply(RESP_NO_RETIRE, '0, last_id);
        end else begin
          s         = cmd_store[retire_at];
          retire_at = next_slot(retire_at);
          free_cnt++;
          r = make_reply(RESP_OK, s.kind, s.id);
        end
      end
      default: r = make_reply(RESP_INVALID, '0, last_id);
    endcase
    return r;
  endfunction

  task automatic note_fault(string msg);
    faults++;
    if (faults <= 10) begin
      $display("%s", msg);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      note_fault($sformatf("reply %0d %s: expected %h, got %h", reply_no, name, want, got));
    end
  endtask

  task automatic compare_reply(out_word_t want, out_word_t got);
    check_field("resp_code", want.resp_code, got.resp_code);
    check_field("out_kind", want.out_kind, got.out_kind);
    check_field("out_id", want.out_id, got.out_id);
    check_field("out_x", want.out_x, got.out_x);
    check_field("out_y", want.out_y, got.out_y);
    check_field("out_z", want.out_z, got.out_z);
    check_field("out_a", want.out_a, got.out_a);
    check_field("out_feed", want.out_feed, got.out_feed);
    check_field("out_clearance", want.out_clearance, got.out_clearance);
    check_field("out_count", want.out_count, got.out_count);
    check_field("free_slots", want.free_slots, got.free_slots);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_queue_state();
      awaited_replies.delete();
    end else begin
      // Replies are matched before new requests are queued in the same cycle.
      if (out_valid && !out_stall) begin
        reply_no++;
        if (awaited_replies.size() == 0) begin
          note_fault($sformatf("reply %0d arrived with no request outstanding", reply_no));
        end else begin
          compare_reply(awaited_replies.pop_front(), out_word);
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_LIMIT_X:    travel_cap[AX_X] = longint'(cfg_data);
          REG_LIMIT_Y:    travel_cap[AX_Y] = longint'(cfg_data);
          REG_LIMIT_Z:    travel_cap[AX_Z] = longint'(cfg_data);
          REG_LIMIT_A:    travel_cap[AX_A] = longint'(cfg_data);
          REG_FEED_LIMIT: feed_cap = cfg_data[FEED_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        awaited_replies.push_back(admit_request(in_word));
      end
    end
    reply_faults <= faults;
    replies_owed <= awaited_replies.size();
  end

endmodule

// ----- test/tb.sv -----
// ---------------------------------------------------------------------------
// Admission queue testbench
// Drives directed and random request words into the admission queue under
// several limit settings, with random gaps and reply stalls, and lets the
// reply checker judge every reply word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mcaq_pkg::*;

  localparam logic [REQ_W-1:0]  REQ_UNKNOWN   = 2'd3;
  localparam logic [KIND_W-1:0] KIND_UNDEF_LO = 3'd4;
  localparam logic [KIND_W-1:0] KIND_UNDEF_HI = 3'd7;

  typedef enum int {TRAFFIC_FILL, TRAFFIC_MIXED, TRAFFIC_DRAIN} traffic_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;
  int                   reply_faults;
  int                   replies_owed;
  logic                 calm = 1'b0;
  int unsigned          travel_cap [AXES] = '{default: 32'h7FFF_FFFF};
  int unsigned          feed_cap = 1500;

  motion_command_admission_queue i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  mcaq_reply_checker u_reply_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .reply_faults (reply_faults),
    .replies_owed (replies_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("motion_command_admission_queue verification failed");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99, 0) < 7);
  end

  task automatic send_request(in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    if (!calm && $urandom_range(99, 0) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(int unsigned lx, int unsigned ly, int unsigned lz,
                            int unsigned la, int unsigned fl);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_LIMIT_X;
    cfg_data  <= LIMIT_W'(lx);
    @(posedge clk);
    cfg_index <= REG_LIMIT_Y;
    cfg_data  <= LIMIT_W'(ly);
    @(posedge clk);
    cfg_index <= REG_LIMIT_Z;
    cfg_data  <= LIMIT_W'(lz);
    @(posedge clk);
    cfg_index <= REG_LIMIT_A;
    cfg_data  <= LIMIT_W'(la);
    @(posedge clk);
    cfg_index <= REG_FEED_LIMIT;
    cfg_data  <= LIMIT_W'(fl);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    travel_cap[AX_X] = lx & 32'h7FFF_FFFF;
    travel_cap[AX_Y] = ly & 32'h7FFF_FFFF;
    travel_cap[AX_Z] = lz & 32'h7FFF_FFFF;
    travel_cap[AX_A] = la & 32'h7FFF_FFFF;
    feed_cap         = fl & 32'h0000_FFFF;
  endtask

  function automatic in_word_t build_command(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                             logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                             logic [POS_W-1:0] z, logic [POS_W-1:0] a,
                                             logic [FEED_W-1:0] feed, logic [MASK_W-1:0] mask,
                                             logic [ARG_W-1:0] clr, logic [ARG_W-1:0] cnt);
    in_word_t w;
    w.req_type     = REQ_SUBMIT;
    w.cmd_kind     = kind;
    w.cmd_id       = id;
    w.pos_x        = x;
    w.pos_y        = y;
    w.pos_z        = z;
    w.pos_a        = a;
    w.feed_rate    = feed;
    w.present_mask = mask;
    w.clearance    = clr;
    w.count_arg    = cnt;
    return w;
  endfunction

  function automatic in_word_t bare_request(logic [REQ_W-1:0] req);
    in_word_t w;
    w          = '0;
    w.req_type = req;
    return w;
  endfunction

  // Coordinates cluster around the travel limit, near zero and far below it.
  function automatic logic [POS_W-1:0] pick_coord(int unsigned cap);
    case ($urandom_range(4, 0))
      0:       return $urandom;
      1:       return POS_W'(cap) + 32'd1 - POS_W'($urandom_range(3, 0));
      2:       return POS_W'($urandom_range(2000, 0)) - 32'd1000;
      3:       return -POS_W'($urandom);
      default: return POS_W'($urandom_range(cap, 0));
    endcase
  endfunction

  function automatic logic [FEED_W-1:0] pick_feed();
    return ($urandom_range(4, 0) == 0) ? FEED_W'($urandom) : FEED_W'($urandom_range(feed_cap, 0));
  endfunction

  function automatic in_word_t random_request(traffic_t mix);
    in_word_t          w;
    int unsigned       roll;
    int unsigned       submit_pct;
    int unsigned       pull_pct;
    int unsigned       retire_pct;
    logic [ARG_W-1:0]  clr;
    logic [POS_W-1:0]  z;
    w.cmd_kind     = KIND_W'($urandom);
    w.cmd_id       = ID_W'($urandom);
    w.pos_x        = $urandom;
    w.pos_y        = $urandom;
    w.pos_z        = $urandom;
    w.pos_a        = $urandom;
    w.feed_rate    = FEED_W'($urandom);
    w.present_mask = MASK_W'($urandom);
    w.clearance    = ARG_W'($urandom);
    w.count_arg    = ARG_W'($urandom);
    case (mix)
      TRAFFIC_FILL: begin
        submit_pct = 80;
        pull_pct   = 90;
        retire_pct = 98;
      end
      TRAFFIC_DRAIN: begin
        submit_pct = 15;
        pull_pct   = 55;
        retire_pct = 97;
      end
      default: begin
        submit_pct = 40;
        pull_pct   = 70;
        retire_pct = 97;
      end
    endcase
    roll       = $urandom_range(99, 0);
    w.req_type = (roll < submit_pct) ? REQ_SUBMIT :
                 (roll < pull_pct)   ? REQ_PULL :
                 (roll < retire_pct) ? REQ_RETIRE : REQ_UNKNOWN;
    if (w.req_type == REQ_SUBMIT) begin
      if ($urandom_range(99, 0) < 6) begin
        w.cmd_kind = KIND_W'($urandom_range(KIND_UNDEF_HI, KIND_UNDEF_LO));
      end else begin
        w.cmd_kind = KIND_W'($urandom_range(KIND_GOTO, KIND_WAIT));
      end
      case (w.cmd_kind)
        KIND_WAIT: begin
          if ($urandom_range(9, 0) == 0) begin
            w.count_arg = '0;
          end
        end
        KIND_SPINDLE: begin
          w.count_arg = ($urandom_range(3, 0) == 0) ?
                        SPINDLE_MAX - 16'd1 + ARG_W'($urandom_range(2, 0)) :
                        ARG_W'($urandom_range(SPINDLE_MAX, 0));
        end
        KIND_DRILL: begin
          w.pos_x     = pick_coord(travel_cap[AX_X]);
          w.pos_y     = pick_coord(travel_cap[AX_Y]);
          clr         = ($urandom_range(3, 0) == 0) ? ARG_W'($urandom) :
                                                       ARG_W'($urandom_range(500, 0));
          z           = pick_coord(travel_cap[AX_Z]) - POS_W'(clr);
          w.pos_z     = z;
          w.clearance = clr;
          w.pos_a     = ($urandom_range(7, 0) == 0) ? $urandom :
                                                       z - POS_W'($urandom_range(1000, 0));
          w.feed_rate = pick_feed();
          if ($urandom_range(9, 0) == 0) begin
            w.count_arg = '0;
          end
        end
        KIND_GOTO: begin
          w.pos_x     = pick_coord(travel_cap[AX_X]);
          w.pos_y     = pick_coord(travel_cap[AX_Y]);
          w.pos_z     = pick_coord(travel_cap[AX_Z]);
          w.pos_a     = pick_coord(travel_cap[AX_A]);
          w.feed_rate = pick_feed();
        end
        default: ;
      endcase
    end
    return w;
  endfunction

  // Traffic rotates between filling, mixed and draining stretches so that
  // the queue reaches both full and empty.
  task automatic run_traffic(int n);
    traffic_t mix;
    mix = TRAFFIC_FILL;
    for (int k = 0; k < n; k++) begin
      if (k % 32 == 0) begin
        mix = traffic_t'((k / 32) % 3);
      end
      send_request(random_request(mix));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(bare_request(REQ_PULL));
    send_request(bare_request(REQ_RETIRE));
    send_request(bare_request(REQ_UNKNOWN));
    send_request(build_command(KIND_WAIT, 16'h0001, '0, '0, '0, '0, '0, '0, '0, 16'd0));
    send_request(build_command(KIND_WAIT, 16'hFFFF, '0, '0, '0, '0, '0, '0, '0, 16'hFFFF));
    send_request(build_command(KIND_SPINDLE, 16'h0002, '0, '0, '0, '0, '0, '0, '0,
                               SPINDLE_MAX));
    send_request(build_command(KIND_SPINDLE, 16'h0003, '0, '0, '0, '0, '0, '0, '0,
                               SPINDLE_MAX + 16'd1));
    send_request(build_command(KIND_SPINDLE, 16'h0004, '0, '0, '0, '0, '0, '0, '0, 16'd0));
    send_request(build_command(KIND_DRILL, 16'h0005, 32'h8000_0000, 32'h7FFF_FFFF, 32'd100,
                               32'h8000_0000, FEED_LIMIT_RESET, 5'h1F, 16'hFFFF, 16'd1));
    send_request(build_command(KIND_DRILL, 16'h0006, 32'd0, 32'd0, 32'd0, 32'd1,
                               16'd100, '0, 16'd10, 16'd3));
    send_request(build_command(KIND_DRILL, 16'h0007, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0,
                               16'd100, '0, 16'd1, 16'd3));
    send_request(build_command(KIND_DRILL, 16'h0008, 32'd5, 32'd5, 32'd50, 32'd10,
                               FEED_LIMIT_RESET + 16'd1, '0, 16'd10, 16'd3));
    send_request(build_command(KIND_DRILL, 16'h0009, 32'd5, 32'd5, 32'd50, 32'd10,
                               16'd100, '0, 16'd10, 16'd0));
    send_request(build_command(KIND_GOTO, 16'h000A, 32'h1234_5678, 32'hDEAD_BEEF, 32'd7,
                               32'd9, 16'd1, '0, '0, '0));
    send_request(build_command(KIND_GOTO, 16'h000B, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 5'h1F, '0, '0));
    send_request(build_command(KIND_GOTO, 16'h000C, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 5'h1F, '0, '0));
    send_request(build_command(KIND_UNDEF_LO, 16'h000D, '0, '0, '0, '0, '0, '0, '0, 16'd1));
    send_request(build_command(KIND_UNDEF_HI, 16'h000E, '0, '0, '0, '0, '0, '0, '0, 16'd1));
    send_request(bare_request(REQ_RETIRE));
    send_request(bare_request(REQ_PULL));
    send_request(bare_request(REQ_PULL));
    send_request(bare_request(REQ_PULL));
    send_request(bare_request(REQ_RETIRE));
    send_request(bare_request(REQ_RETIRE));
    send_request(bare_request(REQ_RETIRE));
    wait_idle();

    calm <= 1'b1;
    set_limits(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_FFFF);
    run_traffic(100);
    wait_idle();

    calm <= 1'b0;
    set_limits($urandom_range(5000, 100), $urandom_range(5000, 100),
               $urandom_range(5000, 100), $urandom_range(5000, 100), 1500);
    run_traffic(100);
    wait_idle();

    set_limits(0, 0, 0, 0, 0);
    run_traffic(80);
    wait_idle();

    set_limits($urandom, $urandom, $urandom, $urandom, $urandom_range(3000, 0));
    run_traffic(120);
    wait_idle();

    if (reply_faults == 0) begin
      $display("motion_command_admission_queue verification clean");
    end else begin
      $display("motion_command_admission_queue verification failed");
    end
    $finish;
  end

endmodule
